### design/dwrf_pkg.sv
package dwrf_pkg;

  localparam int unsigned ENTRIES = 8;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [7:0] EMPTY_MARK = 8'd255;
  localparam logic [7:0] NO_SEQ = 8'hFF;

  typedef enum logic [1:0] {
    OP_VALIDATE = 2'd0,
    OP_ADD      = 2'd1,
    OP_REMOVE   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_LISTED = 3'd1,
    ST_TAG_BAD    = 3'd2,
    ST_REPLAY     = 3'd3,
    ST_FULL       = 3'd4,
    ST_NOT_FOUND  = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] node_id;
    logic [7:0] seq;
    logic       tag_ok;
  } in_beat_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] status;
  } out_beat_t;

  typedef struct packed {
    logic             valid;
    in_beat_t         beat;
    logic             al_match;
    logic [IDX_W-1:0] al_match_idx;
    logic             al_free;
    logic [IDX_W-1:0] al_free_idx;
    logic             ca_hit;
    logic [IDX_W-1:0] ca_hit_idx;
    logic [7:0]       ca_hit_seq;
    logic             ca_free;
    logic [IDX_W-1:0] ca_free_idx;
  } token_t;

  typedef struct packed {
    logic             al_we;
    logic [IDX_W-1:0] al_idx;
    logic [7:0]       al_data;
    logic             ca_we;
    logic [IDX_W-1:0] ca_idx;
    logic [7:0]       ca_id;
    logic [7:0]       ca_seq;
  } wr_cmd_t;

endpackage

### design/dwrf_cell.sv
module dwrf_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [dwrf_pkg::IDX_W-1:0] idx_i,
  input  dwrf_pkg::token_t           tok_i,
  input  dwrf_pkg::wr_cmd_t          wr_i,
  output dwrf_pkg::token_t           tok_o
);
  import dwrf_pkg::*;

  logic [7:0] alw_q;
  logic [7:0] cid_q;
  logic [7:0] cseq_q;
  token_t     tok_d;
  token_t     tok_q;

  always_comb begin
    tok_d = tok_i;
    if (!tok_i.al_match && alw_q == tok_i.beat.node_id) begin
      tok_d.al_match     = 1'b1;
      tok_d.al_match_idx = idx_i;
    end
    if (!tok_i.al_free && alw_q == EMPTY_MARK) begin
      tok_d.al_free     = 1'b1;
      tok_d.al_free_idx = idx_i;
    end
    if (!tok_i.ca_hit && cid_q == tok_i.beat.node_id) begin
      tok_d.ca_hit     = 1'b1;
      tok_d.ca_hit_idx = idx_i;
      tok_d.ca_hit_seq = cseq_q;
    end
    if (!tok_i.ca_free && cid_q == EMPTY_MARK) begin
      tok_d.ca_free     = 1'b1;
      tok_d.ca_free_idx = idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q  <= '0;
      alw_q  <= EMPTY_MARK;
      cid_q  <= EMPTY_MARK;
      cseq_q <= NO_SEQ;
    end else begin
      tok_q <= tok_d;
      if (wr_i.al_we && wr_i.al_idx == idx_i) begin
        alw_q <= wr_i.al_data;
      end
      if (wr_i.ca_we && wr_i.ca_idx == idx_i) begin
        cid_q  <= wr_i.ca_id;
        cseq_q <= wr_i.ca_seq;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

### design/dwrf_judge.sv
module dwrf_judge (
  input  dwrf_pkg::token_t    tok_i,
  output dwrf_pkg::out_beat_t res_o,
  output dwrf_pkg::wr_cmd_t   wr_o
);
  import dwrf_pkg::*;

  logic    is_empty;
  status_e status;

  assign is_empty = (tok_i.beat.node_id == EMPTY_MARK);

  always_comb begin
    res_o.accepted = 1'b0;
    status         = ST_NOT_FOUND;
    wr_o           = '0;
    wr_o.ca_id     = tok_i.beat.node_id;
    wr_o.ca_seq    = tok_i.beat.seq;
    unique case (tok_i.beat.opcode)
      OP_VALIDATE: begin
        if (is_empty || !tok_i.al_match) begin
          status = ST_NOT_LISTED;
        end else if (!tok_i.beat.tag_ok) begin
          status = ST_TAG_BAD;
        end else if (tok_i.ca_hit && tok_i.ca_hit_seq != NO_SEQ &&
                     tok_i.ca_hit_seq == tok_i.beat.seq) begin
          status = ST_REPLAY;
        end else begin
          res_o.accepted = 1'b1;
          status         = ST_OK;
          if (tok_i.ca_hit) begin
            wr_o.ca_we  = tok_i.valid;
            wr_o.ca_idx = tok_i.ca_hit_idx;
          end else if (tok_i.ca_free) begin
            wr_o.ca_we  = tok_i.valid;
            wr_o.ca_idx = tok_i.ca_free_idx;
          end
        end
      end
      OP_ADD: begin
        if (is_empty) begin
          status = ST_NOT_LISTED;
        end else if (!tok_i.al_free) begin
          status = ST_FULL;
        end else begin
          res_o.accepted = 1'b1;
          status         = ST_OK;
          wr_o.al_we     = tok_i.valid;
          wr_o.al_idx    = tok_i.al_free_idx;
          wr_o.al_data   = tok_i.beat.node_id;
        end
      end
      OP_REMOVE: begin
        if (is_empty || !tok_i.al_match) begin
          status = ST_NOT_FOUND;
        end else begin
          res_o.accepted = 1'b1;
          status         = ST_OK;
          wr_o.al_we     = tok_i.valid;
          wr_o.al_idx    = tok_i.al_match_idx;
          wr_o.al_data   = EMPTY_MARK;
        end
      end
      default: begin
        status = ST_NOT_FOUND;
      end
    endcase
    res_o.status = status;
  end

endmodule

### design/device_whitelist_replay_filter.sv
// Channel  Direction  Handshake                   Payload
// in       input      in_valid_i / in_stall_o     in_beat_i  (opcode, node_id, seq, tag_ok)
// out      output     out_valid_o / out_stall_i   out_beat_o (accepted, status)
//
// A request beat walks the row of ENTRIES cells, one cell per cycle, and the
// state write is applied as it leaves the last cell.
// A result is registered into the output as the request leaves the row, and the next
// request is taken only after that, so one request is in the row at a time.
// Reset restores every whitelist and cache entry to the free marker.
// A stalled result is parked, and the next request is taken once it moves on.
module device_whitelist_replay_filter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dwrf_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dwrf_pkg::out_beat_t out_beat_o
);
  import dwrf_pkg::*;

  token_t            tok [ENTRIES+1];
  logic [ENTRIES:1]  tok_valid;
  wr_cmd_t           wr;
  out_beat_t         res;
  logic              busy_q;
  logic              hold_v_q;
  out_beat_t         hold_q;
  logic              out_valid_q;
  out_beat_t         out_q;
  logic              in_acc;
  logic              out_free;
  logic              exit_v;

  assign in_acc   = in_valid_i && !busy_q;
  assign out_free = !out_valid_q || !out_stall_i;
  assign exit_v   = tok[ENTRIES].valid;

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = in_acc;
    tok[0].beat  = in_beat_i;
  end

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    dwrf_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(k)),
      .tok_i  (tok[k]),
      .wr_i   (wr),
      .tok_o  (tok[k+1])
    );
  end

  for (genvar k = 1; k <= ENTRIES; k++) begin : g_vld
    assign tok_valid[k] = tok[k].valid;
  end

  dwrf_judge u_judge (
    .tok_i (tok[ENTRIES]),
    .res_o (res),
    .wr_o  (wr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      hold_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        busy_q <= 1'b1;
      end
      if (exit_v) begin
        if (out_free) begin
          out_valid_q <= 1'b1;
          busy_q      <= 1'b0;
        end else begin
          hold_v_q <= 1'b1;
        end
      end else if (hold_v_q && out_free) begin
        out_valid_q <= 1'b1;
        hold_v_q    <= 1'b0;
        busy_q      <= 1'b0;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (exit_v) begin
      if (out_free) begin
        out_q <= res;
      end else begin
        hold_q <= res;
      end
    end else if (hold_v_q && out_free) begin
      out_q <= hold_q;
    end
  end

  assign in_stall_o  = busy_q;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;

`ifndef NO_ASSERTIONS
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tok_valid) <= 1)
    else $error("more than one request in the cell row");

  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_v |-> busy_q)
    else $error("request left the row while idle");

  a_hold_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_v_q |-> (out_valid_q && busy_q))
    else $error("parked result without a full output register");

  a_exit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exit_v && out_free) |=> (out_valid_q && !busy_q))
    else $error("finished result not presented");
`endif

endmodule

### tb/sv/dwrf_checker.sv
`timescale 1ns / 100ps

module dwrf_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  dwrf_pkg::in_beat_t  in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  dwrf_pkg::out_beat_t out_beat_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import dwrf_pkg::*;

  logic [7:0] listed_ids [ENTRIES];
  logic [7:0] seq_owner_ids [ENTRIES];
  logic [7:0] last_seqs [ENTRIES];
  out_beat_t  verdict_q [$];
  int         fail_count;
  int         pending;

  assign fail_count_o = fail_count;
  assign pending_o    = pending;

  function automatic int find_listed(input logic [7:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (listed_ids[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic int find_cached(input logic [7:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (seq_owner_ids[i] == key) return i;
    end
    return -1;
  endfunction

  task automatic apply_request(input in_beat_t b, output out_beat_t r);
    int s;
    int c;
    r.accepted = 1'b0;
    r.status   = ST_NOT_FOUND;
    case (b.opcode)
      OP_VALIDATE: begin
        if (b.node_id == EMPTY_MARK || find_listed(b.node_id) < 0) begin
          r.status = ST_NOT_LISTED;
        end else if (!b.tag_ok) begin
          r.status = ST_TAG_BAD;
        end else begin
          c = find_cached(b.node_id);
          if (c >= 0 && last_seqs[c] != NO_SEQ && last_seqs[c] == b.seq) begin
            r.status = ST_REPLAY;
          end else begin
            if (c < 0) begin
              c = find_cached(EMPTY_MARK);
              if (c >= 0) seq_owner_ids[c] = b.node_id;
            end
            if (c >= 0) last_seqs[c] = b.seq;
            r.accepted = 1'b1;
            r.status   = ST_OK;
          end
        end
      end
      OP_ADD: begin
        s = find_listed(EMPTY_MARK);
        if (b.node_id == EMPTY_MARK) begin
          r.status = ST_NOT_LISTED;
        end else if (s < 0) begin
          r.status = ST_FULL;
        end else begin
          listed_ids[s] = b.node_id;
          r.accepted    = 1'b1;
          r.status      = ST_OK;
        end
      end
      OP_REMOVE: begin
        s = find_listed(b.node_id);
        if (b.node_id != EMPTY_MARK && s >= 0) begin
          listed_ids[s] = EMPTY_MARK;
          r.accepted    = 1'b1;
          r.status      = ST_OK;
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_beat_t want;
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        listed_ids[i]    = EMPTY_MARK;
        seq_owner_ids[i] = EMPTY_MARK;
        last_seqs[i]     = NO_SEQ;
      end
      verdict_q.delete();
      fail_count = 0;
      pending    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: unexpected result beat, got accepted=%0d status=%0d",
                   $time, out_beat_i.accepted, out_beat_i.status);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_beat_i.accepted !== want.accepted || out_beat_i.status !== want.status) begin
            $display("%0t: result mismatch, expected accepted=%0d status=%0d, got accepted=%0d status=%0d",
                     $time, want.accepted, want.status, out_beat_i.accepted, out_beat_i.status);
            fail_count++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        apply_request(in_beat_i, want);
        verdict_q.push_back(want);
      end
      pending = verdict_q.size();
    end
  end

endmodule

### tb/sv/device_whitelist_replay_filter_tb.sv
`timescale 1ns / 100ps

module device_whitelist_replay_filter_tb;
  import dwrf_pkg::*;

  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int POOL_SIZE = 12;
  localparam int RANDOM_BEATS = 1850;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_beat = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_beat;
  int        fail_count;
  int        pending;
  int        stall_mode = 0;
  int        stall_left = 0;
  logic [7:0] id_pool [POOL_SIZE];

  always #10 clk = ~clk;

  device_whitelist_replay_filter dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_beat_i  (in_beat),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_beat_o (out_beat)
  );

  dwrf_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_beat_i   (in_beat),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_beat_i  (out_beat),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ~out_stall;
    endcase
  end

  function automatic in_beat_t request(input logic [1:0] op, input logic [7:0] id,
                                       input logic [7:0] sq, input logic tag);
    in_beat_t b;
    b.opcode  = op;
    b.node_id = id;
    b.seq     = sq;
    b.tag_ok  = tag;
    return b;
  endfunction

  function automatic in_beat_t random_request();
    in_beat_t b;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) b.opcode = OP_VALIDATE;
    else if (pick < 80) b.opcode = OP_ADD;
    else if (pick < 95) b.opcode = OP_REMOVE;
    else b.opcode = OP_RESERVED;
    if ($urandom_range(0, 9) == 0) b.node_id = 8'($urandom);
    else b.node_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    pick = $urandom_range(0, 9);
    if (pick < 5) b.seq = 8'($urandom_range(0, 3));
    else if (pick < 6) b.seq = NO_SEQ;
    else b.seq = 8'($urandom);
    b.tag_ok = ($urandom_range(0, 7) != 0);
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b);
    @(negedge clk);
    in_valid <= 1'b1;
    in_beat  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain_results();
    pause_sender(0);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int sent;
    int burst;
    bit drained;
    for (int i = 0; i < POOL_SIZE; i++) id_pool[i] = 8'($urandom_range(0, 254));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_beat(request(OP_VALIDATE, 8'h00, 8'h00, 1'b1));
    send_beat(request(OP_VALIDATE, EMPTY_MARK, 8'h00, 1'b1));
    send_beat(request(OP_ADD, EMPTY_MARK, 8'h00, 1'b0));
    send_beat(request(OP_REMOVE, EMPTY_MARK, 8'h00, 1'b0));
    send_beat(request(OP_REMOVE, 8'h5A, 8'h00, 1'b0));
    send_beat(request(OP_RESERVED, 8'hA5, 8'hFF, 1'b1));
    send_beat(request(OP_ADD, 8'h00, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h00, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h81, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h42, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h24, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h18, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'hFE, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h7F, 8'h00, 1'b0));
    send_beat(request(OP_ADD, 8'h33, 8'h00, 1'b0));
    send_beat(request(OP_VALIDATE, 8'h00, 8'h05, 1'b0));
    send_beat(request(OP_VALIDATE, 8'h00, 8'h05, 1'b1));
    send_beat(request(OP_VALIDATE, 8'h00, 8'h05, 1'b1));
    send_beat(request(OP_VALIDATE, 8'h00, NO_SEQ, 1'b1));
    send_beat(request(OP_VALIDATE, 8'h00, NO_SEQ, 1'b1));
    send_beat(request(OP_REMOVE, 8'h00, 8'h00, 1'b0));
    send_beat(request(OP_VALIDATE, 8'h00, 8'hAA, 1'b1));
    send_beat(request(OP_REMOVE, 8'h00, 8'h00, 1'b0));
    send_beat(request(OP_REMOVE, 8'h00, 8'h00, 1'b0));
    send_beat(request(OP_VALIDATE, 8'h00, 8'h01, 1'b1));
    drain_results();

    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        send_beat(random_request());
        sent++;
      end
      if (!drained && sent >= RANDOM_BEATS / 2) begin
        drain_results();
        drained = 1'b1;
      end else begin
        pause_sender($urandom_range(0, 8));
      end
    end

    drain_results();
    repeat (2 * ENTRIES + 4) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
